/* src/power_cap_opp_selector_top_macros.svh */
// Assertion macros for the power-cap operating-point selector.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef POWER_CAP_OPP_SELECTOR_TOP_MACROS_SVH
`define POWER_CAP_OPP_SELECTOR_TOP_MACROS_SVH

// check consequent in the same cycle
`define PCOS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pcos assertion failed");

// check consequent in the cycle after the antecedent
`define PCOS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pcos assertion failed");

`endif

/* src/pcos_pkg.sv */
// Shared types and constants of the power-cap operating-point selector.
// No dependencies.
`default_nettype none

package pcos_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  localparam int unsigned DivSteps = 16;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CfgOppCount    = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgUtilInitial = 1'b1;

  localparam logic [4:0]  OppCountReset = 5'd16;
  localparam logic [15:0] UtilReset     = 16'd100;
  localparam logic [15:0] UtilMax       = 16'hFFFF;
  localparam logic [15:0] UtilMin       = 16'd1;

  localparam logic [2:0] ModeLoad  = 3'd0;
  localparam logic [2:0] ModeArm   = 3'd1;
  localparam logic [2:0] ModeLimit = 3'd2;
  localparam logic [2:0] ModeMeas  = 3'd3;
  localparam logic [2:0] ModeQuery = 3'd4;

  typedef logic [3:0] idx4_t;

  typedef struct packed {
    logic [2:0]  mode;
    idx4_t       entry_index;
    logic [31:0] entry_freq_khz;
    logic [31:0] entry_power_uw;
    logic [39:0] power_limit_uw;
    logic [31:0] measured_power_uw;
    logic [33:0] current_freq_hz;
  } in_t;

  typedef struct packed {
    logic        status;
    idx4_t       target_index;
    logic [31:0] target_freq_khz;
    logic        freq_changed;
    logic [15:0] util_percent;
    logic [31:0] query_uw;
  } out_t;

  typedef struct packed {
    logic [31:0] freq;
    logic [31:0] power;
  } entry_t;

  typedef enum logic [2:0] {
    OpNone,
    OpLoad,
    OpArm,
    OpLimit,
    OpMeas,
    OpQuery
  } op_e;

  typedef struct packed {
    op_e         op;
    idx4_t       entry_index;
    entry_t      entry;
    logic [39:0] limit;
    logic [31:0] measured;
    logic [33:0] hz;
  } cmd_t;

  typedef struct packed {
    logic        done;
    logic        sat;
    logic [15:0] quot;
  } div_res_t;

  typedef struct packed {
    logic idle;
    logic res_push;
  } back_stat_t;

endpackage

`default_nettype wire

/* src/pcos_fifo.sv */
// Two-entry queue of a packed payload type.
// Depends on pcos_pkg for the queue depth.
`default_nettype none

module pcos_fifo import pcos_pkg::*; #(
  parameter type T = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  output logic full_o,
  input  T     data_i,
  input  logic pop_i,
  output logic empty_o,
  output T     data_o
);

  T                 store_q [QueueDepth];
  logic [QPtrW-1:0] wr_q;
  logic [QPtrW-1:0] rd_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (cnt_q == QCntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = store_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + QPtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* src/pcos_front.sv */
// Front end: accepts input items, decodes the mode and queues commands.
// Depends on pcos_pkg and pcos_fifo.
`default_nettype none

module pcos_front import pcos_pkg::*; #(
  parameter int unsigned MAX_POINTS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  output logic full_o,
  input  in_t  in_i,
  output logic cmd_valid_o,
  input  logic cmd_pop_i,
  output cmd_t cmd_o
);

  cmd_t cmd;
  logic cmd_empty;

  always_comb begin
    cmd.entry_index = in_i.entry_index;
    cmd.entry.freq  = in_i.entry_freq_khz;
    cmd.entry.power = in_i.entry_power_uw;
    cmd.limit       = in_i.power_limit_uw;
    cmd.measured    = in_i.measured_power_uw;
    cmd.hz          = in_i.current_freq_hz;
    unique case (in_i.mode)
      ModeLoad:  cmd.op = (32'(in_i.entry_index) < MAX_POINTS) ? OpLoad : OpNone;
      ModeArm:   cmd.op = OpArm;
      ModeLimit: cmd.op = OpLimit;
      ModeMeas:  cmd.op = OpMeas;
      ModeQuery: cmd.op = OpQuery;
      default:   cmd.op = OpNone;
    endcase
  end

  pcos_fifo #(.T(cmd_t)) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .full_o  (full_o),
    .data_i  (cmd),
    .pop_i   (cmd_pop_i),
    .empty_o (cmd_empty),
    .data_o  (cmd_o)
  );

  assign cmd_valid_o = !cmd_empty;

endmodule

`default_nettype wire

/* src/pcos_div.sv */
// Restoring divider with a 16-bit saturating quotient, one bit per cycle.
// Depends on pcos_pkg.
`default_nettype none

module pcos_div import pcos_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [38:0] num_i,
  input  logic [31:0] den_i,
  output div_res_t    res_o
);

  logic               busy_q;
  logic               done_q;
  logic               sat_q;
  logic [DivCntW-1:0] cnt_q;
  logic [31:0]        rem_q;
  logic [31:0]        den_q;
  logic [15:0]        low_q;
  logic [15:0]        quot_q;
  logic               sat_now;
  logic [32:0]        trial;
  logic [32:0]        diff;
  logic               fits;

  assign sat_now = {9'b0, num_i} >= {den_i, 16'b0};
  assign trial   = {rem_q, low_q[15]};
  assign fits    = trial >= {1'b0, den_q};
  assign diff    = trial - {1'b0, den_q};

  assign res_o.done = done_q;
  assign res_o.sat  = sat_q;
  assign res_o.quot = quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      sat_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= !sat_now;
        done_q <= sat_now;
        sat_q  <= sat_now;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DivCntW'(1);
        if (cnt_q == DivCntW'(DivSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {9'b0, num_i[38:16]};
      low_q <= num_i[15:0];
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q  <= fits ? diff[31:0] : trial[31:0];
      low_q  <= {low_q[14:0], 1'b0};
      quot_q <= {quot_q[14:0], fits};
    end
  end

endmodule

`default_nettype wire

/* src/pcos_back.sv */
// Back end: sequencer over the operating-point table, divider and result queue.
// Depends on pcos_pkg, pcos_div and pcos_fifo.
`default_nettype none

module pcos_back import pcos_pkg::*; #(
  parameter int unsigned MAX_POINTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  output logic        cmd_pop_o,
  input  cmd_t        cmd_i,
  input  logic [4:0]  opp_count_i,
  input  logic [15:0] util_initial_i,
  output logic        res_empty_o,
  input  logic        res_pop_i,
  output out_t        res_o,
  output back_stat_t  stat_o
);

  localparam int unsigned IW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [10:0] {
    StIdle    = 11'b000_0000_0001,
    StExec    = 11'b000_0000_0010,
    StArmRd   = 11'b000_0000_0100,
    StLimTop  = 11'b000_0000_1000,
    StLimMul  = 11'b000_0001_0000,
    StLimCmp  = 11'b000_0010_0000,
    StMeasRd  = 11'b000_0100_0000,
    StMeasDiv = 11'b000_1000_0000,
    StQCmp    = 11'b001_0000_0000,
    StFinRd   = 11'b010_0000_0000,
    StFin     = 11'b100_0000_0000
  } state_e;

  state_e      state_q, state_d;
  cmd_t        cmd_q;
  logic [IW-1:0] chosen_q, chosen_d;
  logic [15:0] util_q, util_d;
  logic [31:0] lm_q, lm_d;
  logic        armed_q, armed_d;
  logic [39:0] limit_q, limit_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [47:0] scaled_q, scaled_d;
  logic [47:0] prod_q, prod_d;
  logic        status_q, status_d;
  logic        changed_q, changed_d;
  logic [31:0] power_q, power_d;

  entry_t      mem_q [MAX_POINTS];
  entry_t      rd_q;
  logic [IW-1:0] rd_addr;
  logic        mem_we;

  logic [CW-1:0] n_cnt;
  logic [CW-1:0] idx_inc;
  logic [IW-1:0] top_idx;
  logic [IW-1:0] brk_idx;
  logic [47:0] limit_ext;
  logic [38:0] meas_ext;
  logic [38:0] div_num;
  logic [41:0] freq_ext;
  logic [41:0] freq_hz;
  logic        div_start;
  div_res_t    div_res;
  logic        res_push;
  logic        res_full;
  out_t        res_data;

  always_comb begin
    if (opp_count_i == 5'd0) begin
      n_cnt = CW'(1);
    end else if (32'(opp_count_i) > MAX_POINTS) begin
      n_cnt = CW'(MAX_POINTS);
    end else begin
      n_cnt = CW'(opp_count_i);
    end
  end

  assign top_idx   = IW'(n_cnt - CW'(1));
  assign idx_inc   = idx_q + CW'(1);
  assign brk_idx   = IW'(idx_q - CW'(1));
  assign limit_ext = {8'b0, cmd_q.limit};
  assign meas_ext  = {7'b0, lm_q};
  assign div_num   = (meas_ext << 6) + (meas_ext << 5) + (meas_ext << 2);
  assign freq_ext  = {10'b0, rd_q.freq};
  assign freq_hz   = (freq_ext << 10) - (freq_ext << 4) - (freq_ext << 3);

  always_comb begin
    state_d   = state_q;
    chosen_d  = chosen_q;
    util_d    = util_q;
    lm_d      = lm_q;
    armed_d   = armed_q;
    limit_d   = limit_q;
    idx_d     = idx_q;
    scaled_d  = scaled_q;
    prod_d    = prod_q;
    status_d  = status_q;
    changed_d = changed_q;
    power_d   = power_q;
    rd_addr   = chosen_q;
    mem_we    = 1'b0;
    cmd_pop_o = 1'b0;
    div_start = 1'b0;
    res_push  = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (cmd_valid_i && !res_full) begin
          cmd_pop_o = 1'b1;
          status_d  = 1'b0;
          changed_d = 1'b0;
          power_d   = '0;
          state_d   = StExec;
        end
      end
      StExec: begin
        state_d = StFinRd;
        unique case (cmd_q.op)
          OpLoad: begin
            mem_we = 1'b1;
          end
          OpArm: begin
            rd_addr = top_idx;
            state_d = StArmRd;
          end
          OpLimit: begin
            if (!armed_q) begin
              status_d = 1'b1;
            end else begin
              limit_d  = cmd_q.limit;
              scaled_d = (limit_ext << 6) + (limit_ext << 5) + (limit_ext << 2) + 48'd99;
              rd_addr  = top_idx;
              state_d  = StLimTop;
            end
          end
          OpMeas: begin
            lm_d = cmd_q.measured;
            if (!armed_q) begin
              status_d = 1'b1;
            end else if (cmd_q.measured == '0) begin
              util_d = util_initial_i;
            end else begin
              state_d = StMeasRd;
            end
          end
          OpQuery: begin
            status_d = !armed_q;
            if (lm_q != '0) begin
              power_d = lm_q;
            end else if (armed_q) begin
              idx_d   = '0;
              rd_addr = '0;
              state_d = StQCmp;
            end
          end
          default: ;
        endcase
      end
      StArmRd: begin
        armed_d  = 1'b1;
        limit_d  = {8'b0, rd_q.power};
        chosen_d = top_idx;
        util_d   = UtilReset;
        state_d  = StFinRd;
      end
      StLimTop: begin
        if (limit_q >= {8'b0, rd_q.power}) begin
          chosen_d  = top_idx;
          changed_d = (top_idx != chosen_q);
          state_d   = StFinRd;
        end else if (n_cnt == CW'(1)) begin
          chosen_d  = '0;
          changed_d = (chosen_q != '0);
          state_d   = StFinRd;
        end else begin
          idx_d   = CW'(1);
          rd_addr = IW'(1);
          state_d = StLimMul;
        end
      end
      StLimMul: begin
        prod_d  = {16'b0, rd_q.power} * {32'b0, util_q};
        state_d = StLimCmp;
      end
      StLimCmp: begin
        if (prod_q > scaled_q) begin
          chosen_d  = brk_idx;
          changed_d = (brk_idx != chosen_q);
          state_d   = StFinRd;
        end else if (idx_inc == n_cnt) begin
          chosen_d  = top_idx;
          changed_d = (top_idx != chosen_q);
          state_d   = StFinRd;
        end else begin
          idx_d   = idx_inc;
          rd_addr = IW'(idx_inc);
          state_d = StLimMul;
        end
      end
      StMeasRd: begin
        if (rd_q.power == '0) begin
          util_d  = UtilMax;
          state_d = StFinRd;
        end else begin
          div_start = 1'b1;
          state_d   = StMeasDiv;
        end
      end
      StMeasDiv: begin
        if (div_res.done) begin
          if (div_res.sat) begin
            util_d = UtilMax;
          end else if (div_res.quot == '0) begin
            util_d = UtilMin;
          end else begin
            util_d = div_res.quot;
          end
          state_d = StFinRd;
        end
      end
      StQCmp: begin
        if (freq_hz >= {8'b0, cmd_q.hz}) begin
          power_d = rd_q.power;
          state_d = StFinRd;
        end else if (idx_inc == n_cnt) begin
          power_d = '0;
          state_d = StFinRd;
        end else begin
          idx_d   = idx_inc;
          rd_addr = IW'(idx_inc);
        end
      end
      StFinRd: begin
        state_d = StFin;
      end
      StFin: begin
        res_push = 1'b1;
        state_d  = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      chosen_q <= '0;
      util_q   <= UtilReset;
      lm_q     <= '0;
      armed_q  <= 1'b0;
      limit_q  <= '0;
      idx_q    <= '0;
    end else begin
      state_q  <= state_d;
      chosen_q <= chosen_d;
      util_q   <= util_d;
      lm_q     <= lm_d;
      armed_q  <= armed_d;
      limit_q  <= limit_d;
      idx_q    <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
    end
    scaled_q  <= scaled_d;
    prod_q    <= prod_d;
    status_q  <= status_d;
    changed_q <= changed_d;
    power_q   <= power_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[IW'(cmd_q.entry_index)] <= cmd_q.entry;
    end
    rd_q <= mem_q[rd_addr];
  end

  pcos_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (rd_q.power),
    .res_o   (div_res)
  );

  always_comb begin
    res_data.status          = status_q;
    res_data.target_index    = idx4_t'(chosen_q);
    res_data.target_freq_khz = rd_q.freq;
    res_data.freq_changed    = changed_q;
    res_data.util_percent    = util_q;
    res_data.query_uw        = power_q;
  end

  pcos_fifo #(.T(out_t)) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .full_o  (res_full),
    .data_i  (res_data),
    .pop_i   (res_pop_i),
    .empty_o (res_empty_o),
    .data_o  (res_o)
  );

  assign stat_o.idle     = (state_q == StIdle);
  assign stat_o.res_push = res_push;

endmodule

`default_nettype wire

/* src/power_cap_opp_selector_top.sv */
// Top level of the power-cap operating-point selector: configuration registers,
// front end and back end. Depends on pcos_pkg, pcos_front, pcos_back and the macro header.
//
// Items enter through a two-entry command queue and results leave through a
// two-entry result queue; the back end runs one item at a time. From the head
// of the command queue the back end handles a load, an unused mode and items
// refused because the table is not armed without a table scan; arm reads the
// top table point; a set limit scans table points (one table read and one 32x16
// multiply per point); a query scans points (one point a cycle); and a measured
// power needs no table read when the measurement is zero, is settled after a
// table read when the chosen point's power is zero or the quotient saturates,
// and otherwise is set by the 16-step quotient divider. The table is a memory
// with one write port and a registered read port, which sets the per-point scan
// cost.
`default_nettype none
`include "power_cap_opp_selector_top_macros.svh"

module power_cap_opp_selector_top import pcos_pkg::*; #(
  parameter int unsigned MAX_POINTS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  in_t                 in_data_i,
  output logic                empty,
  input  logic                pop,
  output out_t                out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  logic [4:0]  opp_count_q;
  logic [15:0] util_init_q;
  logic        cmd_valid;
  logic        cmd_pop;
  cmd_t        cmd;
  back_stat_t  back_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opp_count_q <= OppCountReset;
      util_init_q <= UtilReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgOppCount:    opp_count_q <= cfg_wdata_i[4:0];
        CfgUtilInitial: util_init_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  pcos_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .in_i        (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd)
  );

  pcos_back #(.MAX_POINTS(MAX_POINTS)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (cmd_valid),
    .cmd_pop_o      (cmd_pop),
    .cmd_i          (cmd),
    .opp_count_i    (opp_count_q),
    .util_initial_i (util_init_q),
    .res_empty_o    (empty),
    .res_pop_i      (pop),
    .res_o          (out_data_o),
    .stat_o         (back_stat)
  );

  `PCOS_ASSERT_SAME(a_cmd_pop_valid, cmd_pop, cmd_valid)
  `PCOS_ASSERT_NEXT(a_push_queues, push && !full, cmd_valid)
  `PCOS_ASSERT_NEXT(a_pop_starts, cmd_pop, !back_stat.idle)
  `PCOS_ASSERT_NEXT(a_result_shown, back_stat.res_push, !empty)

endmodule

`default_nettype wire
